@@ rtl/mbet_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbet_pkg
// Shared types and constants for the Mandelbrot escape-time pixel unit.
// ----------------------------------------------------------------------------
package mbet_pkg;

  // Default image geometry
  localparam int IMAGE_WIDTH_DEF  = 800;
  localparam int IMAGE_HEIGHT_DEF = 600;

  // Field widths
  localparam int PIX_W   = 10;
  localparam int COORD_W = 32;
  localparam int STEP_W  = 31;
  localparam int LIM_W   = 10;
  localparam int COLOR_W = 8;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  // 2*pixel - size spans the whole image size range (up to 4096)
  localparam int OFF_W = 14;
  // z components: Q.28 with enough integer bits for one step past escape
  localparam int Z_W   = 34;
  // products of the bounded z components (|z| <= 2.0, Q.56)
  localparam int SQ_W  = 60;
  localparam int MUL_W = 32;

  localparam logic signed [Z_W-1:0]  TWO_Q28  = 34'sd536870912;
  localparam logic signed [SQ_W:0]   FOUR_Q56 = 61'sh0400_0000_0000_0000;

  // Color polynomial gains, 255 times 9, 15 and 17 (last one with an extra halving, so 8.5)
  localparam logic [12:0] GAIN_RED   = 13'd2295;
  localparam logic [12:0] GAIN_GREEN = 13'd3825;
  localparam logic [12:0] GAIN_BLUE  = 13'd4335;

  localparam logic [16:0] ONE_Q16 = 17'h10000;

  // Register reset values
  localparam logic signed [COORD_W-1:0] CENTER_REAL_RST = -32'sd134217728;
  localparam logic signed [COORD_W-1:0] CENTER_IMAG_RST = 32'sd0;
  localparam logic [STEP_W-1:0]         PIXEL_STEP_RST  = 31'd1342177;
  localparam logic [LIM_W-1:0]          ITER_LIMIT_RST  = 10'd200;

  typedef enum logic [1:0] {
    REG_CENTER_REAL = 2'd0,
    REG_CENTER_IMAG = 2'd1,
    REG_PIXEL_STEP  = 2'd2,
    REG_ITER_LIMIT  = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CH_RED   = 2'd0,
    CH_GREEN = 2'd1,
    CH_BLUE  = 2'd2
  } color_ch_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAP_RE,
    ST_MAP_IM,
    ST_MAP_FIN,
    ST_ITER_MUL,
    ST_ITER_UPD,
    ST_FIN,
    ST_DIV,
    ST_COLOR_MUL,
    ST_COLOR_ACC,
    ST_OUT
  } state_t;

endpackage

@@ rtl/mandelbrot_escape_time_pixel_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel_top
// Escape-time Mandelbrot pixel unit: maps a pixel to c, iterates z = z^2 + c
// and colors the pixel from the escape count.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall carries one request (pixel column, row).
//   The unit stalls the input while a pixel is being worked on, one pixel at a
//   time. Result channel out_valid/out_stall carries red, green, blue, the
//   escape count and the in-set flag; the result sits in an output register.
//   The APB port (pready tied high) holds center_real, center_imag,
//   pixel_step and iteration_limit at byte addresses 0x0, 0x4, 0x8, 0xC;
//   write them only while no pixel is in flight.
// Sequence:
//   Each pass of the loop runs ITER_MUL, through the multiplier bank (x*x,
//   y*y, x*y), then ITER_UPD for the escape compare and the update. Mapping
//   runs MAP_RE, MAP_IM and MAP_FIN; the count/limit divide gives 16 quotient
//   bits at one quotient bit a cycle; the color polynomials take 12 products
//   through the shared multiplier. A pixel that reaches the limit skips divide
//   and color.
// Reset: rst_n (synchronous) returns to idle, drops out_valid and loads the
//   register defaults. A stalled result holds; the next pixel is taken once
//   the result has moved into the output register.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_pixel_top #(
  parameter int IMAGE_WIDTH  = mbet_pkg::IMAGE_WIDTH_DEF,
  parameter int IMAGE_HEIGHT = mbet_pkg::IMAGE_HEIGHT_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,

  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [mbet_pkg::PIX_W-1:0]   in_pixel_x,
  input  logic [mbet_pkg::PIX_W-1:0]   in_pixel_y,

  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [mbet_pkg::COLOR_W-1:0] out_red,
  output logic [mbet_pkg::COLOR_W-1:0] out_green,
  output logic [mbet_pkg::COLOR_W-1:0] out_blue,
  output logic [mbet_pkg::LIM_W-1:0]   out_escape_count,
  output logic                         out_in_set,

  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mbet_pkg::ADDR_W-1:0]  paddr,
  input  logic [mbet_pkg::DATA_W-1:0]  pwdata,
  output logic [mbet_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);

  localparam int CW = mbet_pkg::COORD_W;
  localparam int ZW = mbet_pkg::Z_W;
  localparam int SW = mbet_pkg::SQ_W;
  localparam int MW = mbet_pkg::MUL_W;
  localparam int OW = mbet_pkg::OFF_W;
  localparam int LW = mbet_pkg::LIM_W;
  localparam int PW = mbet_pkg::PIX_W;
  localparam int KW = mbet_pkg::COLOR_W;

  // Configuration registers
  logic signed [CW-1:0]             center_real_r;
  logic signed [CW-1:0]             center_imag_r;
  logic [mbet_pkg::STEP_W-1:0]      pixel_step_r;
  logic [LW-1:0]                    iter_limit_r;

  // Sequencer and datapath
  mbet_pkg::state_t                 state_r, state_nxt;
  logic [PW-1:0]                    px_r, px_nxt;
  logic [PW-1:0]                    py_r, py_nxt;
  logic signed [2*MW-1:0]           prod_r, prod_nxt;
  logic signed [CW-1:0]             cr_r, cr_nxt;
  logic signed [CW-1:0]             ci_r, ci_nxt;
  logic signed [ZW-1:0]             x_r, x_nxt;
  logic signed [ZW-1:0]             y_r, y_nxt;
  logic signed [SW-1:0]             xx_r, xx_nxt;
  logic signed [SW-1:0]             yy_r, yy_nxt;
  logic signed [SW-1:0]             xy_r, xy_nxt;
  logic [LW-1:0]                    cnt_r, cnt_nxt;
  logic                             in_set_r, in_set_nxt;
  logic [LW-1:0]                    rem_r, rem_nxt;
  logic [15:0]                      t_r, t_nxt;
  logic [3:0]                       step_r, step_nxt;
  logic [16:0]                      acc_r, acc_nxt;
  logic [KW-1:0]                    red_r, red_nxt;
  logic [KW-1:0]                    green_r, green_nxt;
  logic [KW-1:0]                    blue_r, blue_nxt;

  // Output register
  logic                             out_valid_r, out_valid_nxt;
  logic [KW-1:0]                    out_red_r, out_red_nxt;
  logic [KW-1:0]                    out_green_r, out_green_nxt;
  logic [KW-1:0]                    out_blue_r, out_blue_nxt;
  logic [LW-1:0]                    out_count_r, out_count_nxt;
  logic                             out_in_set_r, out_in_set_nxt;

  // Shared multiplier and helpers
  logic signed [MW-1:0]             mul_a, mul_b;
  logic signed [2*MW-1:0]           mul_p;
  logic signed [OW-1:0]             off_x, off_y;
  logic signed [30:0]               xv, yv;
  logic signed [61:0]               yy_p, xy_p;
  logic signed [SW:0]               mag_sum, sq_diff;
  logic [16:0]                      u_q16;
  logic [10:0]                      rem_dbl;
  logic [1:0]                       col_s;
  mbet_pkg::color_ch_t              col_ch;
  logic [12:0]                      col_val;
  logic [KW-1:0]                    col_sat;
  logic                             cfg_wr;

  function automatic logic signed [CW-1:0] sat_add(input logic signed [CW-1:0] c,
                                                    input logic signed [2*MW-1:0] p);
    logic signed [2*MW-1:0] s;
    s = 64'(c) + (p >>> 1);
    if (s > 64'sd2147483647) begin
      sat_add = 32'sh7FFF_FFFF;
    end else if (s < -64'sd2147483648) begin
      sat_add = 32'sh8000_0000;
    end else begin
      sat_add = s[CW-1:0];
    end
  endfunction

  // --------------------------------------------------------------------------
  // APB configuration
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_real_r <= mbet_pkg::CENTER_REAL_RST;
      center_imag_r <= mbet_pkg::CENTER_IMAG_RST;
      pixel_step_r  <= mbet_pkg::PIXEL_STEP_RST;
      iter_limit_r  <= mbet_pkg::ITER_LIMIT_RST;
    end else if (cfg_wr) begin
      case (mbet_pkg::cfg_reg_t'(paddr[3:2]))
        mbet_pkg::REG_CENTER_REAL: center_real_r <= signed'(pwdata);
        mbet_pkg::REG_CENTER_IMAG: center_imag_r <= signed'(pwdata);
        mbet_pkg::REG_PIXEL_STEP:  pixel_step_r  <= pwdata[mbet_pkg::STEP_W-1:0];
        mbet_pkg::REG_ITER_LIMIT:  iter_limit_r  <= pwdata[LW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (mbet_pkg::cfg_reg_t'(paddr[3:2]))
      mbet_pkg::REG_CENTER_REAL: prdata = center_real_r;
      mbet_pkg::REG_CENTER_IMAG: prdata = center_imag_r;
      mbet_pkg::REG_PIXEL_STEP:  prdata = 32'(pixel_step_r);
      mbet_pkg::REG_ITER_LIMIT:  prdata = 32'(iter_limit_r);
      default:                   prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath helpers
  // --------------------------------------------------------------------------
  assign off_x   = signed'({3'b000, px_r, 1'b0} - OW'(IMAGE_WIDTH));
  assign off_y   = signed'({3'b000, py_r, 1'b0} - OW'(IMAGE_HEIGHT));
  assign xv      = x_r[30:0];
  assign yv      = y_r[30:0];
  assign yy_p    = yv * yv;
  assign xy_p    = xv * yv;
  assign mag_sum = (SW+1)'(xx_r) + (SW+1)'(yy_r);
  assign sq_diff = (SW+1)'(xx_r) - (SW+1)'(yy_r);
  assign u_q16   = mbet_pkg::ONE_Q16 - 17'(t_r);
  assign rem_dbl = {rem_r, 1'b0};
  assign col_s   = step_r[1:0];
  assign col_ch  = mbet_pkg::color_ch_t'(step_r[3:2]);
  assign col_val = (col_ch == mbet_pkg::CH_BLUE) ? prod_r[29:17] : prod_r[28:16];
  assign col_sat = (col_val > 13'd255) ? 8'hFF : col_val[KW-1:0];

  // Operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      mbet_pkg::ST_MAP_RE: begin
        mul_a = MW'(off_x);
        mul_b = signed'(MW'(pixel_step_r));
      end
      mbet_pkg::ST_MAP_IM: begin
        mul_a = MW'(off_y);
        mul_b = signed'(MW'(pixel_step_r));
      end
      mbet_pkg::ST_ITER_MUL: begin
        mul_a = MW'(xv);
        mul_b = MW'(xv);
      end
      mbet_pkg::ST_COLOR_MUL: begin
        mul_a = (col_s == 2'd0) ? signed'(MW'(u_q16)) : signed'(MW'(acc_r));
        case (col_s)
          2'd0: mul_b = (col_ch == mbet_pkg::CH_RED) ? signed'(MW'(t_r))
                                                     : signed'(MW'(u_q16));
          2'd1: mul_b = (col_ch == mbet_pkg::CH_BLUE) ? signed'(MW'(u_q16))
                                                      : signed'(MW'(t_r));
          2'd2: mul_b = signed'(MW'(t_r));
          default: begin
            case (col_ch)
              mbet_pkg::CH_RED:   mul_b = signed'(MW'(mbet_pkg::GAIN_RED));
              mbet_pkg::CH_GREEN: mul_b = signed'(MW'(mbet_pkg::GAIN_GREEN));
              default:            mul_b = signed'(MW'(mbet_pkg::GAIN_BLUE));
            endcase
          end
        endcase
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mbet_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    px_r         <= px_nxt;
    py_r         <= py_nxt;
    prod_r       <= prod_nxt;
    cr_r         <= cr_nxt;
    ci_r         <= ci_nxt;
    x_r          <= x_nxt;
    y_r          <= y_nxt;
    xx_r         <= xx_nxt;
    yy_r         <= yy_nxt;
    xy_r         <= xy_nxt;
    cnt_r        <= cnt_nxt;
    in_set_r     <= in_set_nxt;
    rem_r        <= rem_nxt;
    t_r          <= t_nxt;
    step_r       <= step_nxt;
    acc_r        <= acc_nxt;
    red_r        <= red_nxt;
    green_r      <= green_nxt;
    blue_r       <= blue_nxt;
    out_red_r    <= out_red_nxt;
    out_green_r  <= out_green_nxt;
    out_blue_r   <= out_blue_nxt;
    out_count_r  <= out_count_nxt;
    out_in_set_r <= out_in_set_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    px_nxt         = px_r;
    py_nxt         = py_r;
    prod_nxt       = prod_r;
    cr_nxt         = cr_r;
    ci_nxt         = ci_r;
    x_nxt          = x_r;
    y_nxt          = y_r;
    xx_nxt         = xx_r;
    yy_nxt         = yy_r;
    xy_nxt         = xy_r;
    cnt_nxt        = cnt_r;
    in_set_nxt     = in_set_r;
    rem_nxt        = rem_r;
    t_nxt          = t_r;
    step_nxt       = step_r;
    acc_nxt        = acc_r;
    red_nxt        = red_r;
    green_nxt      = green_r;
    blue_nxt       = blue_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_red_nxt    = out_red_r;
    out_green_nxt  = out_green_r;
    out_blue_nxt   = out_blue_r;
    out_count_nxt  = out_count_r;
    out_in_set_nxt = out_in_set_r;

    case (state_r)
      mbet_pkg::ST_IDLE: begin
        if (in_valid) begin
          px_nxt    = in_pixel_x;
          py_nxt    = in_pixel_y;
          state_nxt = mbet_pkg::ST_MAP_RE;
        end
      end
      mbet_pkg::ST_MAP_RE: begin
        prod_nxt  = mul_p;
        state_nxt = mbet_pkg::ST_MAP_IM;
      end
      mbet_pkg::ST_MAP_IM: begin
        cr_nxt    = sat_add(center_real_r, prod_r);
        prod_nxt  = mul_p;
        state_nxt = mbet_pkg::ST_MAP_FIN;
      end
      mbet_pkg::ST_MAP_FIN: begin
        ci_nxt    = sat_add(center_imag_r, prod_r);
        x_nxt     = '0;
        y_nxt     = '0;
        cnt_nxt   = '0;
        state_nxt = mbet_pkg::ST_ITER_MUL;
      end
      mbet_pkg::ST_ITER_MUL: begin
        // beyond 2.0 on either axis counts as escaped without squaring
        if (cnt_r >= iter_limit_r ||
            x_r > mbet_pkg::TWO_Q28 || x_r < -mbet_pkg::TWO_Q28 ||
            y_r > mbet_pkg::TWO_Q28 || y_r < -mbet_pkg::TWO_Q28) begin
          state_nxt = mbet_pkg::ST_FIN;
        end else begin
          xx_nxt    = mul_p[SW-1:0];
          yy_nxt    = yy_p[SW-1:0];
          xy_nxt    = xy_p[SW-1:0];
          state_nxt = mbet_pkg::ST_ITER_UPD;
        end
      end
      mbet_pkg::ST_ITER_UPD: begin
        if (mag_sum > mbet_pkg::FOUR_Q56) begin
          state_nxt = mbet_pkg::ST_FIN;
        end else begin
          x_nxt     = ZW'(signed'(sq_diff[SW:28])) + ZW'(cr_r);
          y_nxt     = ZW'(signed'(xy_r[SW-1:27])) + ZW'(ci_r);
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = mbet_pkg::ST_ITER_MUL;
        end
      end
      mbet_pkg::ST_FIN: begin
        in_set_nxt = (cnt_r == iter_limit_r);
        if (cnt_r == iter_limit_r) begin
          red_nxt   = '0;
          green_nxt = '0;
          blue_nxt  = '0;
          state_nxt = mbet_pkg::ST_OUT;
        end else begin
          rem_nxt   = cnt_r;
          step_nxt  = '0;
          state_nxt = mbet_pkg::ST_DIV;
        end
      end
      mbet_pkg::ST_DIV: begin
        // restoring divide: t = count * 2^16 / limit, one bit a cycle
        if (rem_dbl >= 11'(iter_limit_r)) begin
          rem_nxt = LW'(rem_dbl - 11'(iter_limit_r));
          t_nxt   = {t_r[14:0], 1'b1};
        end else begin
          rem_nxt = rem_dbl[LW-1:0];
          t_nxt   = {t_r[14:0], 1'b0};
        end
        step_nxt = step_r + 1'b1;
        if (step_r == 4'd15) begin
          step_nxt  = '0;
          state_nxt = mbet_pkg::ST_COLOR_MUL;
        end
      end
      mbet_pkg::ST_COLOR_MUL: begin
        prod_nxt  = mul_p;
        state_nxt = mbet_pkg::ST_COLOR_ACC;
      end
      mbet_pkg::ST_COLOR_ACC: begin
        if (col_s != 2'd3) begin
          acc_nxt = prod_r[32:16];
        end else begin
          case (col_ch)
            mbet_pkg::CH_RED:   red_nxt   = col_sat;
            mbet_pkg::CH_GREEN: green_nxt = col_sat;
            default:            blue_nxt  = col_sat;
          endcase
        end
        step_nxt = step_r + 1'b1;
        if (col_ch == mbet_pkg::CH_BLUE && col_s == 2'd3) begin
          state_nxt = mbet_pkg::ST_OUT;
        end else begin
          state_nxt = mbet_pkg::ST_COLOR_MUL;
        end
      end
      mbet_pkg::ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_red_nxt    = red_r;
          out_green_nxt  = green_r;
          out_blue_nxt   = blue_r;
          out_count_nxt  = cnt_r;
          out_in_set_nxt = in_set_r;
          state_nxt      = mbet_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mbet_pkg::ST_IDLE;
    endcase
  end

  assign in_stall         = (state_r != mbet_pkg::ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_red          = out_red_r;
  assign out_green        = out_green_r;
  assign out_blue         = out_blue_r;
  assign out_escape_count = out_count_r;
  assign out_in_set       = out_in_set_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_accept_starts_map: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r == mbet_pkg::ST_MAP_RE)
    else $error("accepted request did not start mapping");

  a_result_from_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == mbet_pkg::ST_OUT)
    else $error("result raised outside the output state");

  a_black_in_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_in_set_r |->
      (out_red_r == '0 && out_green_r == '0 && out_blue_r == '0))
    else $error("in-set pixel is not black");

  a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == mbet_pkg::ST_DIV |=>
      (state_r == mbet_pkg::ST_DIV || state_r == mbet_pkg::ST_COLOR_MUL))
    else $error("divider left to an unexpected state");

endmodule

@@ test/mandelbrot_escape_time_pixel_top_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel_top_test
// Drives pixel requests through the escape-time unit under a series of view
// settings (reset view, deep zoom at the largest limit, zero and unit limits,
// saturated centers and step, random views) and checks every color, count and
// in-set flag against a behavioral Mandelbrot model kept in a scoreboard.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_pixel_top_test;

  localparam int PW = mbet_pkg::PIX_W;
  localparam int DW = mbet_pkg::DATA_W;

  typedef struct packed {
    logic [mbet_pkg::COLOR_W-1:0] red;
    logic [mbet_pkg::COLOR_W-1:0] green;
    logic [mbet_pkg::COLOR_W-1:0] blue;
    logic [mbet_pkg::LIM_W-1:0]   count;
    logic                         in_set;
  } pixel_color_t;

  class pixel_scoreboard;
    longint       center_re;
    longint       center_im;
    longint       step;
    longint       limit;
    pixel_color_t expected_colors[$];
    int           failures;
    int           matched;
    int           black_seen;

    function new();
      center_re  = mbet_pkg::CENTER_REAL_RST;
      center_im  = mbet_pkg::CENTER_IMAG_RST;
      step       = mbet_pkg::PIXEL_STEP_RST;
      limit      = mbet_pkg::ITER_LIMIT_RST;
      failures   = 0;
      matched    = 0;
      black_seen = 0;
    endfunction

    function void write_reg(mbet_pkg::cfg_reg_t r, logic [DW-1:0] v);
      case (r)
        mbet_pkg::REG_CENTER_REAL: center_re = longint'($signed(v));
        mbet_pkg::REG_CENTER_IMAG: center_im = longint'($signed(v));
        mbet_pkg::REG_PIXEL_STEP:  step = longint'(v[mbet_pkg::STEP_W-1:0]);
        mbet_pkg::REG_ITER_LIMIT:  limit = longint'(v[mbet_pkg::LIM_W-1:0]);
        default: ;
      endcase
    endfunction

    // center + floor((2*pix - size) * step / 2), clamped to Q4.28
    function longint plane_coord(logic [PW-1:0] pix, longint size, longint center);
      longint off;
      longint c;
      off = (2 * longint'(pix) - size) * step;
      c = center + (off >>> 1);
      if (c > 64'sd2147483647) c = 64'sd2147483647;
      if (c < -64'sd2147483648) c = -64'sd2147483648;
      return c;
    endfunction

    function longint q16_mul(longint a, longint b);
      return (a * b) >>> 16;
    endfunction

    function logic [mbet_pkg::COLOR_W-1:0] clip_255(longint v);
      return (v > 255) ? 8'd255 : v[mbet_pkg::COLOR_W-1:0];
    endfunction

    function pixel_color_t escape_color(logic [PW-1:0] px, logic [PW-1:0] py);
      longint       cr, ci, x, y, xx, yy, xy, n, t, u;
      longint       two_q28, four_q56;
      pixel_color_t r;
      two_q28  = 64'sd1 << 29;
      four_q56 = 64'sd1 << 58;
      cr = plane_coord(px, mbet_pkg::IMAGE_WIDTH_DEF, center_re);
      ci = plane_coord(py, mbet_pkg::IMAGE_HEIGHT_DEF, center_im);
      x = 0;
      y = 0;
      n = 0;
      while (n < limit) begin
        // a component past 2.0 has escaped already
        if (x > two_q28 || x < -two_q28 || y > two_q28 || y < -two_q28) break;
        xx = x * x;
        yy = y * y;
        if (xx + yy > four_q56) break;
        xy = x * y;
        x = ((xx - yy) >>> 28) + cr;
        y = ((2 * xy) >>> 28) + ci;
        n++;
      end
      r = '0;
      r.count  = n[mbet_pkg::LIM_W-1:0];
      r.in_set = (n == limit);
      if (!r.in_set) begin
        t = (n << 16) / limit;
        u = 65536 - t;
        r.red   = clip_255((2295 * q16_mul(q16_mul(q16_mul(u, t), t), t)) >>> 16);
        r.green = clip_255((3825 * q16_mul(q16_mul(q16_mul(u, u), t), t)) >>> 16);
        r.blue  = clip_255((4335 * q16_mul(q16_mul(q16_mul(u, u), u), t)) >>> 17);
      end
      return r;
    endfunction

    function void note_request(logic [PW-1:0] px, logic [PW-1:0] py);
      expected_colors.push_back(escape_color(px, py));
    endfunction

    function void check_result(pixel_color_t got);
      pixel_color_t exp_c;
      if (expected_colors.size() == 0) begin
        $error("result with no request pending: count %0d", got.count);
        failures++;
        return;
      end
      exp_c = expected_colors.pop_front();
      if (got.red !== exp_c.red) begin
        $error("red: expected %0d, got %0d", exp_c.red, got.red);
        failures++;
      end
      if (got.green !== exp_c.green) begin
        $error("green: expected %0d, got %0d", exp_c.green, got.green);
        failures++;
      end
      if (got.blue !== exp_c.blue) begin
        $error("blue: expected %0d, got %0d", exp_c.blue, got.blue);
        failures++;
      end
      if (got.count !== exp_c.count) begin
        $error("escape_count: expected %0d, got %0d", exp_c.count, got.count);
        failures++;
      end
      if (got.in_set !== exp_c.in_set) begin
        $error("in_set: expected %0d, got %0d", exp_c.in_set, got.in_set);
        failures++;
      end
      matched++;
      if (exp_c.in_set) black_seen++;
    endfunction

    function int pending();
      return expected_colors.size();
    endfunction
  endclass

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_stall;
  logic [PW-1:0]                in_pixel_x;
  logic [PW-1:0]                in_pixel_y;
  logic                         out_valid;
  logic                         out_stall;
  logic [mbet_pkg::COLOR_W-1:0] out_red;
  logic [mbet_pkg::COLOR_W-1:0] out_green;
  logic [mbet_pkg::COLOR_W-1:0] out_blue;
  logic [mbet_pkg::LIM_W-1:0]   out_escape_count;
  logic                         out_in_set;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [mbet_pkg::ADDR_W-1:0]  paddr;
  logic [DW-1:0]                pwdata;
  logic [DW-1:0]                prdata;
  logic                         pready;

  pixel_scoreboard board;
  bit              hold_wanted;
  bit              hold_finished;
  int              view_count;

  mandelbrot_escape_time_pixel_top i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_pixel_x       (in_pixel_x),
    .in_pixel_y       (in_pixel_y),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_escape_count (out_escape_count),
    .out_in_set       (out_in_set),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: random stall segments, plus one long hold-off on request
  initial begin : result_sink
    int seg_len;
    int style;
    out_stall <= 1'b0;
    forever begin
      if (hold_wanted && !hold_finished) begin
        out_stall <= 1'b1;
        repeat (3000) @(posedge clk);
        hold_finished = 1'b1;
      end else begin
        style   = $urandom_range(0, 3);
        seg_len = $urandom_range(1, 40);
        repeat (seg_len) begin
          case (style)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 1) == 0);
            2: out_stall <= ($urandom_range(0, 7) == 0);
            default: out_stall <= 1'b1;
          endcase
          @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      board.check_result('{out_red, out_green, out_blue, out_escape_count, out_in_set});
    end
  end

  // called at a rising edge; returns at the edge where the request was taken
  task automatic offer_pixel(input logic [PW-1:0] px, input logic [PW-1:0] py);
    in_valid   <= 1'b1;
    in_pixel_x <= px;
    in_pixel_y <= py;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_request(px, py);
  endtask

  task automatic stream_pixels(input int n);
    int            sent;
    int            burst;
    int            gap;
    logic [PW-1:0] px;
    logic [PW-1:0] py;
    sent = 0;
    while (sent < n) begin
      burst = $urandom_range(1, 8);
      for (int k = 0; k < burst && sent < n; k++) begin
        if ($urandom_range(0, 7) == 0) begin
          // anywhere in the 10-bit range, outside the image too
          px = PW'($urandom);
          py = PW'($urandom);
        end else begin
          px = PW'($urandom_range(0, mbet_pkg::IMAGE_WIDTH_DEF - 1));
          py = PW'($urandom_range(0, mbet_pkg::IMAGE_HEIGHT_DEF - 1));
        end
        offer_pixel(px, py);
        sent++;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
  endtask

  task automatic reg_write(input mbet_pkg::cfg_reg_t r, input logic [DW-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    board.write_reg(r, v);
  endtask

  task automatic set_view(input logic [DW-1:0] re, input logic [DW-1:0] im,
                          input logic [DW-1:0] st, input logic [DW-1:0] lim);
    reg_write(mbet_pkg::REG_CENTER_REAL, re);
    reg_write(mbet_pkg::REG_CENTER_IMAG, im);
    reg_write(mbet_pkg::REG_PIXEL_STEP, st);
    reg_write(mbet_pkg::REG_ITER_LIMIT, lim);
    view_count++;
  endtask

  task automatic wait_drained();
    while (board.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin : main_seq
    board         = new();
    hold_wanted   = 1'b0;
    hold_finished = 1'b0;
    view_count    = 1;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_pixel_x <= '0;
    in_pixel_y <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset view: corners, center of the image (inside the set), beyond the image
    offer_pixel(10'd0, 10'd0);
    offer_pixel(10'd799, 10'd599);
    offer_pixel(10'd400, 10'd300);
    offer_pixel(10'd1023, 10'd1023);
    offer_pixel(10'd0, 10'd1023);
    offer_pixel(10'd1023, 10'd0);
    offer_pixel(10'd512, 10'd256);
    offer_pixel(10'd300, 10'd350);
    in_valid <= 1'b0;
    hold_wanted = 1'b1;
    stream_pixels(350);
    wait_drained();

    // deep view at the largest limit, few pixels since in-set ones are slow
    set_view(-32'sd201326592, 32'sd26843546, 32'd262144, 32'd1023);
    stream_pixels(40);
    wait_drained();

    // zero step: every pixel lands on the center; unit limit
    set_view($urandom, $urandom, 32'd0, 32'd1);
    offer_pixel(10'd0, 10'd0);
    offer_pixel(10'd1023, 10'd1023);
    in_valid <= 1'b0;
    stream_pixels(60);
    wait_drained();

    // zero limit: no iteration, every pixel black
    set_view(-32'sd134217728, 32'sd0, 32'd1342177, 32'd0);
    offer_pixel(10'd400, 10'd300);
    offer_pixel(10'd1023, 10'd0);
    in_valid <= 1'b0;
    stream_pixels(20);
    wait_drained();

    // largest center and step: c saturates on both ends
    set_view(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'd37);
    offer_pixel(10'd0, 10'd0);
    offer_pixel(10'd1023, 10'd1023);
    offer_pixel(10'd400, 10'd300);
    offer_pixel(10'd399, 10'd301);
    in_valid <= 1'b0;
    stream_pixels(150);
    wait_drained();

    set_view(32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 32'd64);
    stream_pixels(100);
    wait_drained();

    // random views, one of them with unconstrained centers and step
    for (int v = 0; v < 5; v++) begin
      if (v == 4) begin
        set_view($urandom, $urandom, $urandom_range(0, 32'h7FFF_FFFF),
                 $urandom_range(1, 120));
      end else begin
        set_view($urandom_range(0, 32'h4000_0000) - 32'h2000_0000,
                 $urandom_range(0, 32'h4000_0000) - 32'h2000_0000,
                 $urandom_range(32'h4000, 32'h40_0000), $urandom_range(1, 120));
      end
      stream_pixels(150);
      wait_drained();
    end

    set_view(mbet_pkg::CENTER_REAL_RST, mbet_pkg::CENTER_IMAG_RST,
             DW'(mbet_pkg::PIXEL_STEP_RST), DW'(mbet_pkg::ITER_LIMIT_RST));
    stream_pixels(200);
    wait_drained();
    repeat (500) @(posedge clk);

    $display("Checked %0d pixels (%0d black) over %0d view settings.",
             board.matched, board.black_seen, view_count);
    $display("Views covered limits 0, 1 and 1023, saturated centers and step, zero step.");
    if (board.failures == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin : watchdog
    #40_000_000;
    $display("Timed out with %0d results outstanding.", board.pending());
    $display("FAILED: results differ");
    $finish;
  end

endmodule
